// ===== rtl/dwt_pkg.sv =====
// ----------------------------------------------------------------------------
// dwt_pkg
// Shared types and constants for the two-wheel encoder tachometer.
// ----------------------------------------------------------------------------
package dwt_pkg;

  // Field and register widths
  localparam int unsigned RPM_W    = 32;
  localparam int unsigned TMO_W    = 32;
  localparam int unsigned DPE_W    = 16;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned SPEED_W  = 32;
  localparam int unsigned TRAVEL_W = 48;
  localparam int unsigned OUT_W    = 2 * (SPEED_W + TRAVEL_W);
  localparam int unsigned IN_W     = 8;

  // Divider: dividend is rpm_numerator * 16, one quotient bit per step
  localparam int unsigned DIV_W    = RPM_W + 4;
  localparam int unsigned STEP_W   = 6;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_W - 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RPM_NUM  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_PER = 2'd2;

  // Register reset values
  localparam logic [RPM_W-1:0] RPM_NUM_RST  = 32'd133333333;
  localparam logic [TMO_W-1:0] TIMEOUT_RST  = 32'd20000000;
  localparam logic [DPE_W-1:0] DIST_PER_RST = 16'd640;

  // Input item kinds (tuser)
  localparam logic ACT_TICK   = 1'b0;
  localparam logic ACT_REPORT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_L,
    ST_START_R,
    ST_DIV_R,
    ST_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic tick_en;
    logic mul_en;
    logic div_start;
    logic div_step;
    logic sel_right;
    logic store_left;
    logic load_out;
  } dwt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;
  } dwt_status_t;

endpackage

// ===== rtl/dual_wheel_tachometer.sv =====
// ----------------------------------------------------------------------------
// dual_wheel_tachometer
// Two-wheel encoder period tachometer: edge counting per tick, speed and
// travel for both wheels on a report request.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// s_axis    in   tuser: action; tdata: left_level, right_level
// m_axis    out  tdata: left_speed, left_travel, right_speed, right_travel
// cfg       in   cfg_idx_i selects register, cfg_data_i value, cfg_we_i strobe
//
// Ticks may arrive back to back while no report is in progress.
// A report runs the shared restoring divider, which yields one quotient bit
// per cycle over 36 bits, once per wheel.
// Reset clears wheel edge state and loads register defaults; no clearing pass.
// A waiting result does not block ticks; a finished report holds until the
// output register is free.
// ----------------------------------------------------------------------------
module dual_wheel_tachometer
  import dwt_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_W-1:0]      s_axis_tdata,  // [0] left_level, [1] right_level
  input  logic                 s_axis_tuser,  // [0] action
  // output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_W-1:0]     m_axis_tdata   // left_speed, left_travel,
                                              // right_speed, right_travel
);

  dwt_cmd_t    cmd;
  dwt_status_t status;

  dwt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_action_i (s_axis_tuser),
    .s_ready_o  (s_axis_tready),
    .m_ready_i  (m_axis_tready),
    .m_valid_o  (m_axis_tvalid),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  dwt_datapath #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .left_level_i  (s_axis_tdata[0]),
    .right_level_i (s_axis_tdata[1]),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_data_o    (m_axis_tdata)
  );

endmodule

// ===== rtl/dwt_ctrl.sv =====
// ----------------------------------------------------------------------------
// dwt_ctrl
// Sequencer for tick and report transactions and the output valid flag.
// ----------------------------------------------------------------------------
module dwt_ctrl
  import dwt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_action_i,
  output logic        s_ready_o,
  input  logic        m_ready_i,
  output logic        m_valid_o,
  output dwt_cmd_t    cmd_o,
  input  dwt_status_t status_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // State and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d   = state_q;
    s_ready_o = 1'b0;
    cmd_o     = '0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          if (s_action_i == ACT_TICK) begin
            cmd_o.tick_en = 1'b1;
          end else begin
            cmd_o.mul_en    = 1'b1;
            cmd_o.div_start = 1'b1;
            state_d         = ST_DIV_L;
          end
        end
      end
      ST_DIV_L: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = ST_START_R;
      end
      ST_START_R: begin
        cmd_o.store_left = 1'b1;
        cmd_o.div_start  = 1'b1;
        cmd_o.sel_right  = 1'b1;
        state_d          = ST_DIV_R;
      end
      ST_DIV_R: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.sel_right = 1'b1;
        if (status_i.div_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        // wait for the output slot to free up
        if (!out_valid_q || m_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output register valid
  always_comb begin
    if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (m_ready_i) out_valid_d = 1'b0;
    else                out_valid_d = out_valid_q;
  end

  assign m_valid_o = out_valid_q;

endmodule

// ===== rtl/dwt_datapath.sv =====
// ----------------------------------------------------------------------------
// dwt_datapath
// Edge counters, config registers, travel multipliers, shared restoring
// divider and the output data register.
// ----------------------------------------------------------------------------
module dwt_datapath
  import dwt_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 left_level_i,
  input  logic                 right_level_i,
  input  dwt_cmd_t             cmd_i,
  output dwt_status_t          status_o,
  output logic [OUT_W-1:0]     out_data_o
);

  localparam int unsigned CW    = COUNTER_WIDTH;
  localparam int unsigned CMP_W = (CW > TMO_W) ? CW : TMO_W;

  // Configuration registers
  logic [RPM_W-1:0] rpm_num_q;
  logic [TMO_W-1:0] timeout_q;
  logic [DPE_W-1:0] dist_per_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rpm_num_q  <= RPM_NUM_RST;
      timeout_q  <= TIMEOUT_RST;
      dist_per_q <= DIST_PER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RPM_NUM:  rpm_num_q  <= cfg_data_i[RPM_W-1:0];
        REG_TIMEOUT:  timeout_q  <= cfg_data_i[TMO_W-1:0];
        REG_DIST_PER: dist_per_q <= cfg_data_i[DPE_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-wheel edge state, index 0 left, 1 right
  logic [1:0]               prev_q;
  logic [1:0][CW-1:0]       elapsed_q;
  logic [1:0][CW-1:0]       period_q;
  logic [1:0][COUNT_W-1:0]  count_q;
  logic [1:0]               level;
  logic [1:0][CW-1:0]       next_cnt;
  logic [1:0]               rise;
  logic [1:0]               zero_spd;

  assign level = {right_level_i, left_level_i};

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      next_cnt[i] = (&elapsed_q[i]) ? elapsed_q[i] : elapsed_q[i] + CW'(1);
      rise[i]     = level[i] & ~prev_q[i];
      zero_spd[i] = (period_q[i] == '0) ||
                    (CMP_W'(elapsed_q[i]) >= CMP_W'(timeout_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      elapsed_q <= '0;
      period_q  <= '0;
      count_q   <= '0;
    end else if (cmd_i.tick_en) begin
      for (int i = 0; i < 2; i++) begin
        prev_q[i] <= level[i];
        if (rise[i]) begin
          period_q[i]  <= next_cnt[i];
          elapsed_q[i] <= '0;
          count_q[i]   <= count_q[i] + COUNT_W'(1);
        end else begin
          elapsed_q[i] <= next_cnt[i];
        end
      end
    end
  end

  // Travel: one 32x16 product per wheel, registered
  logic [1:0][TRAVEL_W-1:0] travel_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      for (int i = 0; i < 2; i++) begin
        travel_q[i] <= TRAVEL_W'(count_q[i]) * TRAVEL_W'(dist_per_q);
      end
    end
  end

  // Restoring divider, one quotient bit per step
  logic [STEP_W-1:0] step_q;
  logic [DIV_W-1:0]  quo_q;
  logic [CW-1:0]     rem_q;
  logic [CW-1:0]     dvsr_q;
  logic              zero_q;
  logic [CW:0]       trial;
  logic [CW:0]       diff;
  logic              fits;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign diff  = trial - {1'b0, dvsr_q};
  assign fits  = trial >= {1'b0, dvsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.div_start) begin
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      step_q <= step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      quo_q  <= {rpm_num_q, 4'b0000};
      rem_q  <= '0;
      dvsr_q <= cmd_i.sel_right ? period_q[1] : period_q[0];
      zero_q <= cmd_i.sel_right ? zero_spd[1] : zero_spd[0];
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[DIV_W-2:0], fits};
      rem_q <= fits ? diff[CW-1:0] : trial[CW-1:0];
    end
  end

  assign status_o.div_last = (step_q == STEP_LAST);

  // Speed: forced zero or saturated quotient
  logic [SPEED_W-1:0] speed_now;
  logic [SPEED_W-1:0] speed_l_q;

  always_comb begin
    if (zero_q)                    speed_now = '0;
    else if (|quo_q[DIV_W-1:SPEED_W]) speed_now = '1;
    else                           speed_now = quo_q[SPEED_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_left) speed_l_q <= speed_now;
  end

  // Output data register
  logic [OUT_W-1:0] out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) out_q <= {travel_q[1], speed_now, travel_q[0], speed_l_q};
  end

  assign out_data_o = out_q;

endmodule
